/* sv/wbp_pkg.sv */
// Shared constants and types for the wildcard byte pattern patch finder.
// No dependencies; compiled first.
package wbp_pkg;

    localparam int PATTERN_MAX   = 16;
    localparam int OFFSET_BITS   = 32;
    localparam int CFG_POSITIONS = 16;
    // positions actually compared: the smaller of the window and the config
    localparam int NPOS      = (PATTERN_MAX < CFG_POSITIONS) ? PATTERN_MAX : CFG_POSITIONS;
    localparam int POS_BITS  = (NPOS > 1) ? $clog2(NPOS) : 1;
    localparam int LEN_BITS  = $clog2(NPOS + 1);

    localparam int DATA_BITS    = 8;
    localparam int OUT_OFF_BITS = 32;
    localparam int CFG_LEN_BITS = 5;
    localparam int MASK_BITS    = 16;
    localparam int REG_BITS     = 64;
    localparam int ADDR_BITS    = 6;
    localparam int REG_IDX_BITS = 3;

    typedef enum logic [1:0] {
        ST_PATCH     = 2'd0,
        ST_MATCHED   = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_PAT_LO  = 3'd0,
        REG_PAT_HI  = 3'd1,
        REG_WILD    = 3'd2,
        REG_RMASK   = 3'd3,
        REG_REP_LO  = 3'd4,
        REG_REP_HI  = 3'd5,
        REG_LEN     = 3'd6
    } t_reg_idx;

endpackage

/* sv/wbp_in_if.sv */
// Input channel of the pattern finder: one image byte per item.
// Depends on wbp_pkg.
interface wbp_in_if;
    import wbp_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [DATA_BITS-1:0] data_byte;
    logic                 first_of_image;
    logic                 last_of_image;

    modport source(output valid, data_byte, first_of_image, last_of_image, input ready);
    modport sink(input valid, data_byte, first_of_image, last_of_image, output ready);
endinterface

/* sv/wbp_out_if.sv */
// Result channel of the pattern finder: patch entries and match status.
// Depends on wbp_pkg.
interface wbp_out_if;
    import wbp_pkg::*;

    logic                    valid;
    logic                    ready;
    t_status                 status;
    logic [OUT_OFF_BITS-1:0] byte_offset;
    logic [DATA_BITS-1:0]    new_byte;
    logic                    last;

    modport source(output valid, status, byte_offset, new_byte, last, input ready);
    modport sink(input valid, status, byte_offset, new_byte, last, output ready);
endinterface

/* sv/wildcard_byte_pattern_patch_finder_core.sv */
// Wildcard byte pattern search over an image stream, with patch list output.
// Depends on wbp_pkg, wbp_in_if, wbp_out_if.
//
// Usage:
//   i_in carries one image byte per item with first/last-of-image flags.
//   o_out carries results: one patch entry per replacement position in
//   pattern order, or a single "matched" or "not found" item; last marks
//   the final result of a run. The APB port (64-bit data, registers at
//   8*index) holds the pattern; write it only while the block is idle.
//   Throughput: one byte per cycle while scanning. The byte is shifted into
//   the window register, compared against the pattern in the next cycle,
//   and any results pass through the result sequencer into a one-entry
//   output register. When a run reports, the input stalls until the
//   result sequencer has handed out all results, one per cycle while the
//   receiver is ready. Bytes after a run has reported are taken and
//   dropped until a byte with first_of_image set. A stalled receiver
//   holds the output register and, through the sequencer, the input.
//   Reset (synchronous, active low) clears the configuration registers to
//   zero, the offset counter, the done flag and all valid flags.
module wildcard_byte_pattern_patch_finder_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    wbp_in_if.sink                        i_in,
    wbp_out_if.source                     o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wbp_pkg::ADDR_BITS-1:0] paddr,
    input  logic [wbp_pkg::REG_BITS-1:0]  pwdata,
    output logic [wbp_pkg::REG_BITS-1:0]  prdata,
    output logic                          pready
);
    import wbp_pkg::*;

    // configuration
    logic [REG_BITS-1:0]     r_pat_lo, r_pat_hi, r_rep_lo, r_rep_hi;
    logic [MASK_BITS-1:0]    r_wild, r_rmask;
    logic [CFG_LEN_BITS-1:0] r_len;
    t_reg_idx                reg_idx;
    logic                    cfg_wr;

    // scan state
    logic [DATA_BITS-1:0]    r_win [NPOS];
    logic [OFFSET_BITS-1:0]  r_seen;
    logic                    r_done;
    logic                    r_chk, r_chk_last;
    logic [OFFSET_BITS-1:0]  r_off;

    // result sequencer
    logic                    r_em_active;
    t_status                 r_em_kind;
    logic [NPOS-1:0]         r_em_mask;
    logic [OFFSET_BITS-1:0]  r_em_base;

    // output register
    logic                    r_ov;
    t_status                 r_st;
    logic [OUT_OFF_BITS-1:0] r_boff;
    logic [DATA_BITS-1:0]    r_nb;
    logic                    r_olast;

    logic [DATA_BITS-1:0]    pat_byte [NPOS];
    logic [DATA_BITS-1:0]    rep_byte [NPOS];
    logic [LEN_BITS-1:0]     eff_len, len_m1;
    logic [NPOS-1:0]         len_mask;
    logic                    hit, fire, accept, take;
    logic [POS_BITS-1:0]     sel;
    logic [NPOS-1:0]         sel_bit;
    logic [DATA_BITS-1:0]    sel_byte;
    logic                    slot_free;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[ADDR_BITS-1 -: REG_IDX_BITS]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo <= '0;
            r_pat_hi <= '0;
            r_wild   <= '0;
            r_rmask  <= '0;
            r_rep_lo <= '0;
            r_rep_hi <= '0;
            r_len    <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_PAT_LO: r_pat_lo <= pwdata;
                REG_PAT_HI: r_pat_hi <= pwdata;
                REG_WILD:   r_wild   <= pwdata[MASK_BITS-1:0];
                REG_RMASK:  r_rmask  <= pwdata[MASK_BITS-1:0];
                REG_REP_LO: r_rep_lo <= pwdata;
                REG_REP_HI: r_rep_hi <= pwdata;
                REG_LEN:    r_len    <= pwdata[CFG_LEN_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_PAT_LO: prdata = r_pat_lo;
            REG_PAT_HI: prdata = r_pat_hi;
            REG_WILD:   prdata = REG_BITS'(r_wild);
            REG_RMASK:  prdata = REG_BITS'(r_rmask);
            REG_REP_LO: prdata = r_rep_lo;
            REG_REP_HI: prdata = r_rep_hi;
            REG_LEN:    prdata = REG_BITS'(r_len);
            default:    prdata = '0;
        endcase
    end

    // ---------------- pattern decode ----------------
    always_comb begin
        for (int i = 0; i < NPOS; i++) begin
            pat_byte[i] = (i < 8) ? r_pat_lo[8*(i%8) +: 8] : r_pat_hi[8*(i%8) +: 8];
            rep_byte[i] = (i < 8) ? r_rep_lo[8*(i%8) +: 8] : r_rep_hi[8*(i%8) +: 8];
        end
    end

    assign eff_len = (r_len > CFG_LEN_BITS'(NPOS)) ? LEN_BITS'(NPOS)
                                                   : LEN_BITS'(r_len);
    assign len_m1  = eff_len - LEN_BITS'(1);

    always_comb begin
        for (int i = 0; i < NPOS; i++) begin
            len_mask[i] = (LEN_BITS'(i) < eff_len);
        end
    end

    // ---------------- window compare ----------------
    // position i lines up with the byte taken (len-1-i) items ago
    always_comb begin
        logic [LEN_BITS-1:0] d;
        hit = r_chk && (eff_len != '0) && (r_off >= OFFSET_BITS'(len_m1));
        for (int i = 0; i < NPOS; i++) begin
            d = len_m1 - LEN_BITS'(i);
            if (len_mask[i] && !r_wild[i] && (r_win[d[POS_BITS-1:0]] != pat_byte[i])) begin
                hit = 1'b0;
            end
        end
    end

    assign fire       = r_chk && (hit || r_chk_last);
    assign i_in.ready = i_rst_n && !r_em_active && !fire;
    assign accept     = i_in.valid && i_in.ready;
    // a taken byte is scanned unless the run already reported
    assign take       = accept && (i_in.first_of_image || !r_done);

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_win[0] <= i_in.data_byte;
            for (int k = 1; k < NPOS; k++) begin
                r_win[k] <= r_win[k-1];
            end
            r_off      <= i_in.first_of_image ? '0 : r_seen;
            r_chk_last <= i_in.last_of_image;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            r_done <= 1'b0;
            r_chk  <= 1'b0;
        end else begin
            r_chk <= take;
            if (take) begin
                if (i_in.first_of_image) begin
                    r_seen <= OFFSET_BITS'(1);
                end else if (r_seen != '1) begin
                    r_seen <= r_seen + OFFSET_BITS'(1);
                end
            end
            if (accept && i_in.first_of_image) begin
                r_done <= 1'b0;
            end else if (fire) begin
                r_done <= 1'b1;
            end
        end
    end

    // ---------------- result sequencer ----------------
    always_comb begin
        logic found;
        found = 1'b0;
        sel   = '0;
        for (int i = 0; i < NPOS; i++) begin
            if (r_em_mask[i] && !found) begin
                sel   = POS_BITS'(i);
                found = 1'b1;
            end
        end
    end

    always_comb begin
        sel_bit  = NPOS'(1) << sel;
        sel_byte = '0;
        for (int i = 0; i < NPOS; i++) begin
            if (sel == POS_BITS'(i)) begin
                sel_byte = rep_byte[i];
            end
        end
    end

    assign slot_free = !r_ov || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_em_active <= 1'b0;
        end else if (fire) begin
            r_em_active <= 1'b1;
        end else if (r_em_active && slot_free) begin
            if (r_em_kind != ST_PATCH || (r_em_mask & ~sel_bit) == '0) begin
                r_em_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_em_mask <= r_rmask[NPOS-1:0] & len_mask;
            r_em_base <= r_off - OFFSET_BITS'(len_m1);
            if (!hit) begin
                r_em_kind <= ST_NOT_FOUND;
            end else if ((r_rmask[NPOS-1:0] & len_mask) != '0) begin
                r_em_kind <= ST_PATCH;
            end else begin
                r_em_kind <= ST_MATCHED;
            end
        end else if (r_em_active && slot_free) begin
            r_em_mask <= r_em_mask & ~sel_bit;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (slot_free) begin
            r_ov <= r_em_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_em_active && slot_free) begin
            r_st <= r_em_kind;
            case (r_em_kind)
                ST_PATCH: begin
                    r_boff  <= OUT_OFF_BITS'(r_em_base + OFFSET_BITS'(sel));
                    r_nb    <= sel_byte;
                    r_olast <= ((r_em_mask & ~sel_bit) == '0);
                end
                ST_MATCHED: begin
                    r_boff  <= OUT_OFF_BITS'(r_em_base);
                    r_nb    <= '0;
                    r_olast <= 1'b1;
                end
                default: begin
                    r_boff  <= '0;
                    r_nb    <= '0;
                    r_olast <= 1'b1;
                end
            endcase
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.status      = r_st;
    assign o_out.byte_offset = r_boff;
    assign o_out.new_byte    = r_nb;
    assign o_out.last        = r_olast;

endmodule
